// ===== rtl/scss_pkg.sv =====
package scss_pkg;

  localparam int unsigned TABLE_POINTS = 360;
  localparam int unsigned FRAME_BYTES  = 10;
  localparam int unsigned SINE_POINTS  = 360;
  localparam int unsigned FRAME_KEEP   = 3;
  localparam int unsigned FIFO_DEPTH   = 3;

  localparam int unsigned IDX_W  = $clog2(TABLE_POINTS);
  localparam int unsigned SUM_W  = ((IDX_W > 8) ? IDX_W : 8) + 1;
  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES);
  localparam int unsigned KEEP_W = $clog2(FRAME_KEEP);
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned PROD_W  = 16 + $clog2(TABLE_POINTS + 1);
  localparam int unsigned M1_W    = PROD_W - 6;
  localparam int unsigned Q_W     = PROD_W - 6;
  localparam int unsigned MUL1_W  = PROD_W + M1_W;
  localparam int unsigned M2_W    = Q_W - 9;
  localparam int unsigned W_W     = Q_W - 9;
  localparam int unsigned MUL2_W  = Q_W + M2_W;
  localparam int unsigned WSAT_W  = (W_W > 8) ? W_W : 9;
  localparam int unsigned RECIP_100  = (2 ** PROD_W) / 100;
  localparam int unsigned RECIP_1000 = (2 ** Q_W) / 1000;
  localparam int unsigned STEP_STAGES = 5;

  localparam logic [9:0] SUM_RESET   = 10'd102;
  localparam logic [9:0] THOU_WRAP   = 10'd1000;

  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [7:0] BYTE_TERM = 8'hFF;
  localparam logic [7:0] BYTE_ACT  = 8'h71;
  localparam logic [7:0] SEL_IDLE  = 8'hA0;
  localparam logic [7:0] SEL_FREQ  = 8'hA1;
  localparam logic [7:0] SEL_SWEEP = 8'hA2;
  localparam logic [7:0] SEL_DEBUG = 8'hB0;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FREQ  = 2'd1,
    MODE_SWEEP = 2'd2,
    MODE_DEBUG = 2'd3
  } mode_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } close_t;

  typedef struct packed {
    logic start;
    logic clear;
  } step_ctl_t;

  typedef logic [7:0] wave_t [TABLE_POINTS];

  localparam logic [7:0] SINE360 [SINE_POINTS] = '{
    8'd128,8'd125,8'd123,8'd121,8'd119,8'd116,8'd114,8'd112,8'd110,8'd108,
    8'd105,8'd103,8'd101,8'd99,8'd97,8'd95,8'd92,8'd90,8'd88,8'd86,
    8'd84,8'd82,8'd80,8'd78,8'd76,8'd74,8'd72,8'd70,8'd68,8'd66,
    8'd64,8'd62,8'd60,8'd58,8'd56,8'd54,8'd53,8'd51,8'd49,8'd47,
    8'd46,8'd44,8'd42,8'd41,8'd39,8'd37,8'd36,8'd34,8'd33,8'd31,
    8'd30,8'd28,8'd27,8'd26,8'd24,8'd23,8'd22,8'd21,8'd19,8'd18,
    8'd17,8'd16,8'd15,8'd14,8'd13,8'd12,8'd11,8'd10,8'd9,8'd8,
    8'd8,8'd7,8'd6,8'd6,8'd5,8'd4,8'd4,8'd3,8'd3,8'd2,
    8'd2,8'd2,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0,8'd0,8'd0,
    8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd2,
    8'd2,8'd2,8'd3,8'd3,8'd4,8'd4,8'd5,8'd6,8'd6,8'd7,
    8'd8,8'd8,8'd9,8'd10,8'd11,8'd12,8'd13,8'd14,8'd15,8'd16,
    8'd17,8'd18,8'd19,8'd21,8'd22,8'd23,8'd24,8'd26,8'd27,8'd28,
    8'd30,8'd31,8'd33,8'd34,8'd36,8'd37,8'd39,8'd41,8'd42,8'd44,
    8'd46,8'd47,8'd49,8'd51,8'd53,8'd54,8'd56,8'd58,8'd60,8'd62,
    8'd64,8'd66,8'd68,8'd70,8'd72,8'd74,8'd76,8'd78,8'd80,8'd82,
    8'd84,8'd86,8'd88,8'd90,8'd92,8'd95,8'd97,8'd99,8'd101,8'd103,
    8'd105,8'd108,8'd110,8'd112,8'd114,8'd116,8'd119,8'd121,8'd123,8'd125,
    8'd128,8'd130,8'd132,8'd134,8'd136,8'd139,8'd141,8'd143,8'd145,8'd147,
    8'd150,8'd152,8'd154,8'd156,8'd158,8'd160,8'd163,8'd165,8'd167,8'd169,
    8'd171,8'd173,8'd175,8'd177,8'd179,8'd181,8'd183,8'd185,8'd187,8'd189,
    8'd191,8'd193,8'd195,8'd197,8'd199,8'd201,8'd202,8'd204,8'd206,8'd208,
    8'd209,8'd211,8'd213,8'd214,8'd216,8'd218,8'd219,8'd221,8'd222,8'd224,
    8'd225,8'd227,8'd228,8'd229,8'd231,8'd232,8'd233,8'd234,8'd236,8'd237,
    8'd238,8'd239,8'd240,8'd241,8'd242,8'd243,8'd244,8'd245,8'd246,8'd247,
    8'd247,8'd248,8'd249,8'd249,8'd250,8'd251,8'd251,8'd252,8'd252,8'd253,
    8'd253,8'd253,8'd254,8'd254,8'd254,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd254,8'd254,8'd254,8'd253,
    8'd253,8'd253,8'd252,8'd252,8'd251,8'd251,8'd250,8'd249,8'd249,8'd248,
    8'd247,8'd247,8'd246,8'd245,8'd244,8'd243,8'd242,8'd241,8'd240,8'd239,
    8'd238,8'd237,8'd236,8'd234,8'd233,8'd232,8'd231,8'd229,8'd228,8'd227,
    8'd225,8'd224,8'd222,8'd221,8'd219,8'd218,8'd216,8'd214,8'd213,8'd211,
    8'd209,8'd208,8'd206,8'd204,8'd202,8'd201,8'd199,8'd197,8'd195,8'd193,
    8'd191,8'd189,8'd187,8'd185,8'd183,8'd181,8'd179,8'd177,8'd175,8'd173,
    8'd171,8'd169,8'd167,8'd165,8'd163,8'd160,8'd158,8'd156,8'd154,8'd152,
    8'd150,8'd147,8'd145,8'd143,8'd141,8'd139,8'd136,8'd134,8'd132,8'd130
  };

  function automatic wave_t build_wave();
    wave_t w;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      w[i] = SINE360[(i * SINE_POINTS) / TABLE_POINTS];
    end
    return w;
  endfunction

  localparam wave_t WAVE = build_wave();

endpackage

// ===== rtl/serial_commanded_sine_synthesizer.sv =====
// Sine synthesizer commanded over a serial byte stream.
// Slave channel: tuser selects the kind of word (0 = received serial byte in
// tdata, 1 = sample tick). Master channel: one 8-bit unsigned sample per
// tick while output runs, midscale 128; ticks while stopped give nothing.
// Bytes build a frame that closes on three 0xFF bytes in a row or when the
// frame is full; the first byte selects a mode or acts in the current one.
// Any byte stops output, unless it closes a frame that starts output.
// Throughput: one word per cycle while tready is high. A frame that loads a new
// frequency holds tready low while the step unit (a multiply and two
// reciprocal divides with correction) works out the phase steps.
// A tick's sample passes a synchronous sine ROM read register and then an
// output queue entry before it appears on the master side.
// Stall: a 3-word output queue absorbs samples; tready drops when it and the
// ROM read in flight would fill it, so nothing is lost.
// Reset: idle mode, output stopped, phase 0, thousandths sum 102, steps 0.
module serial_commanded_sine_synthesizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  input  logic       s_axis_tuser_i,   // [0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [7:0] dac_sample
);

  scss_pkg::close_t    close;
  scss_pkg::step_ctl_t step_ctl;
  scss_pkg::mode_e     mode_q, mode_d;

  logic                       run_q, run_d;
  logic [scss_pkg::IDX_W-1:0] idx_q, idx_d, idx_nxt;
  logic [9:0]                 sum_q, sum_d, sum_nxt;
  logic [10:0]                sum_ext;
  logic                       carry;
  logic [scss_pkg::SUM_W-1:0] idx_sum;
  logic                       in_acc, byte_acc, tick_acc;
  logic                       step_busy, wave_room, rd_en;
  logic [7:0]                 whole;
  logic [9:0]                 thou;

  assign s_axis_tready_o = !step_busy && wave_room;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_acc = in_acc && (s_axis_tuser_i == scss_pkg::OP_BYTE);
  assign tick_acc = in_acc && (s_axis_tuser_i == scss_pkg::OP_TICK);

  scss_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .byte_i       (s_axis_tdata_i),
    .close_o      (close)
  );

  scss_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (step_ctl),
    .freq_i  ({close.b2, close.b1}),
    .busy_o  (step_busy),
    .whole_o (whole),
    .thou_o  (thou)
  );

  scss_wave u_wave (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q),
    .room_o    (wave_room),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

  always_comb begin
    sum_ext = {1'b0, sum_q} + {1'b0, thou};
    carry   = sum_ext >= {1'b0, scss_pkg::THOU_WRAP};
    sum_nxt = carry ? 10'(sum_ext - {1'b0, scss_pkg::THOU_WRAP}) : sum_ext[9:0];
    idx_sum = scss_pkg::SUM_W'(idx_q) + scss_pkg::SUM_W'(whole) + scss_pkg::SUM_W'(carry);
    if (idx_sum >= scss_pkg::SUM_W'(scss_pkg::TABLE_POINTS)) begin
      idx_nxt = scss_pkg::IDX_W'(idx_sum - scss_pkg::SUM_W'(scss_pkg::TABLE_POINTS));
    end else begin
      idx_nxt = scss_pkg::IDX_W'(idx_sum);
    end
  end

  always_comb begin
    mode_d         = mode_q;
    run_d          = run_q;
    idx_d          = idx_q;
    sum_d          = sum_q;
    step_ctl.start = 1'b0;
    step_ctl.clear = 1'b0;
    rd_en          = 1'b0;
    if (byte_acc) begin
      run_d = 1'b0;
      if (close.valid) begin
        unique case (close.b0)
          scss_pkg::SEL_IDLE: begin
            mode_d         = scss_pkg::MODE_IDLE;
            idx_d          = '0;
            sum_d          = scss_pkg::SUM_RESET;
            step_ctl.clear = 1'b1;
          end
          scss_pkg::SEL_FREQ:  mode_d = scss_pkg::MODE_FREQ;
          scss_pkg::SEL_SWEEP: mode_d = scss_pkg::MODE_SWEEP;
          scss_pkg::SEL_DEBUG: mode_d = scss_pkg::MODE_DEBUG;
          default: begin
            unique case (mode_q)
              scss_pkg::MODE_IDLE: begin
                idx_d          = '0;
                sum_d          = scss_pkg::SUM_RESET;
                step_ctl.clear = 1'b1;
                if (close.b0 == scss_pkg::BYTE_ACT) begin
                  step_ctl.start = 1'b1;
                  run_d          = 1'b1;
                end
              end
              scss_pkg::MODE_FREQ: begin
                if (close.b0 == scss_pkg::BYTE_ACT) begin
                  step_ctl.start = 1'b1;
                  run_d          = 1'b1;
                end
              end
              scss_pkg::MODE_SWEEP: begin
                if (close.b0 == scss_pkg::BYTE_ACT) begin
                  run_d = 1'b1;
                end
              end
              scss_pkg::MODE_DEBUG: run_d = 1'b1;
              default: run_d = run_q;
            endcase
          end
        endcase
      end
    end else if (tick_acc && run_q) begin
      rd_en = 1'b1;
      idx_d = idx_nxt;
      sum_d = sum_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= scss_pkg::MODE_IDLE;
      run_q  <= 1'b0;
      idx_q  <= '0;
      sum_q  <= scss_pkg::SUM_RESET;
    end else begin
      mode_q <= mode_d;
      run_q  <= run_d;
      idx_q  <= idx_d;
      sum_q  <= sum_d;
    end
  end

  a_busy_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_busy |-> !s_axis_tready_o)
    else $error("input accepted while step unit busy");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < (scss_pkg::IDX_W + 1)'(scss_pkg::TABLE_POINTS))
    else $error("table index out of range");

  a_sum_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q < scss_pkg::THOU_WRAP)
    else $error("thousandths sum out of range");

endmodule

// ===== rtl/scss_frame.sv =====
module scss_frame (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           byte_i,
  output scss_pkg::close_t     close_o
);

  logic [scss_pkg::CNT_W-1:0] count_q, count_d;
  logic [1:0]                 term_q, term_d;
  logic [7:0]                 fb_q [scss_pkg::FRAME_KEEP];
  logic                       last;

  always_comb begin
    if (byte_i == scss_pkg::BYTE_TERM) begin
      term_d = (term_q == 2'd3) ? 2'd3 : term_q + 2'd1;
    end else begin
      term_d = 2'd0;
    end
    last = (term_d == 2'd3) ||
           (count_q == scss_pkg::CNT_W'(scss_pkg::FRAME_BYTES - 1));
    count_d = last ? '0 : count_q + scss_pkg::CNT_W'(1);
  end

  // forward the incoming word into the slot it lands in
  always_comb begin
    close_o.valid = byte_valid_i && last;
    close_o.b0 = (count_q == scss_pkg::CNT_W'(0)) ? byte_i : fb_q[0];
    close_o.b1 = (count_q == scss_pkg::CNT_W'(1)) ? byte_i : fb_q[1];
    close_o.b2 = (count_q == scss_pkg::CNT_W'(2)) ? byte_i : fb_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      term_q  <= '0;
    end else if (byte_valid_i) begin
      count_q <= count_d;
      term_q  <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i && (count_q < scss_pkg::CNT_W'(scss_pkg::FRAME_KEEP))) begin
      fb_q[count_q[scss_pkg::KEEP_W-1:0]] <= byte_i;
    end
  end

endmodule

// ===== rtl/scss_step.sv =====
module scss_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scss_pkg::step_ctl_t   ctl_i,
  input  logic [15:0]           freq_i,
  output logic                  busy_o,
  output logic [7:0]            whole_o,
  output logic [9:0]            thou_o
);

  logic [scss_pkg::STEP_STAGES-1:0] stg_q;
  logic [scss_pkg::PROD_W-1:0]      s_q;
  logic [scss_pkg::Q_W-1:0]         qe_q, q_q;
  logic [scss_pkg::W_W-1:0]         we_q;
  logic [7:0]                       whole_q, whole_d;
  logic [9:0]                       thou_q, thou_d;

  logic [scss_pkg::MUL1_W-1:0]      prod1;
  logic [scss_pkg::PROD_W-1:0]      r1;
  logic [scss_pkg::MUL2_W-1:0]      prod2;
  logic [scss_pkg::Q_W-1:0]         r2;
  logic                             fix2;
  logic [scss_pkg::W_W-1:0]         w;
  logic [scss_pkg::WSAT_W-1:0]      w_ext;

  always_comb begin
    prod1 = scss_pkg::MUL1_W'(s_q) * scss_pkg::MUL1_W'(scss_pkg::RECIP_100);
    r1    = s_q - scss_pkg::PROD_W'(qe_q) * scss_pkg::PROD_W'(100);
    prod2 = scss_pkg::MUL2_W'(q_q) * scss_pkg::MUL2_W'(scss_pkg::RECIP_1000);
    r2    = q_q - scss_pkg::Q_W'(we_q) * scss_pkg::Q_W'(1000);
    fix2  = r2 >= scss_pkg::Q_W'(1000);
    w     = we_q + scss_pkg::W_W'(fix2);
    w_ext = scss_pkg::WSAT_W'(w);
    whole_d = (w_ext > scss_pkg::WSAT_W'(255)) ? 8'hFF : w_ext[7:0];
    thou_d  = fix2 ? 10'(r2 - scss_pkg::Q_W'(1000)) : r2[9:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q   <= '0;
      whole_q <= '0;
      thou_q  <= '0;
    end else begin
      stg_q <= {stg_q[scss_pkg::STEP_STAGES-2:0], ctl_i.start};
      if (ctl_i.clear) begin
        whole_q <= '0;
        thou_q  <= '0;
      end else if (stg_q[scss_pkg::STEP_STAGES-1]) begin
        whole_q <= whole_d;
        thou_q  <= thou_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      s_q <= scss_pkg::PROD_W'(freq_i) * scss_pkg::PROD_W'(scss_pkg::TABLE_POINTS);
    end
    if (stg_q[0]) begin
      qe_q <= prod1[scss_pkg::PROD_W +: scss_pkg::Q_W];
    end
    if (stg_q[1]) begin
      q_q <= qe_q + scss_pkg::Q_W'(r1 >= scss_pkg::PROD_W'(100));
    end
    if (stg_q[2]) begin
      we_q <= prod2[scss_pkg::Q_W +: scss_pkg::W_W];
    end
  end

  assign busy_o  = |stg_q;
  assign whole_o = whole_q;
  assign thou_o  = thou_q;

endmodule

// ===== rtl/scss_wave.sv =====
module scss_wave (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [scss_pkg::IDX_W-1:0] rd_addr_i,
  output logic                       room_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [7:0]                 m_data_o
);

  logic [7:0]                  rom_q;
  logic                        s1_q;
  logic [7:0]                  buf_q [scss_pkg::FIFO_DEPTH];
  logic [scss_pkg::PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [scss_pkg::FCNT_W-1:0] cnt_q;
  logic                        pop;

  function automatic logic [scss_pkg::PTR_W-1:0] ptr_inc(
    input logic [scss_pkg::PTR_W-1:0] p
  );
    return (p == scss_pkg::PTR_W'(scss_pkg::FIFO_DEPTH - 1)) ? '0 : p + scss_pkg::PTR_W'(1);
  endfunction

  assign m_valid_o = cnt_q != '0;
  assign pop       = m_valid_o && m_ready_i;
  assign m_data_o  = buf_q[rd_ptr_q];
  assign room_o    = (cnt_q + scss_pkg::FCNT_W'(s1_q)) < scss_pkg::FCNT_W'(scss_pkg::FIFO_DEPTH);

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rom_q <= scss_pkg::WAVE[rd_addr_i];
    end
    if (s1_q) begin
      buf_q[wr_ptr_q] <= rom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      s1_q <= rd_en_i;
      if (s1_q) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cnt_q <= cnt_q + scss_pkg::FCNT_W'(s1_q) - scss_pkg::FCNT_W'(pop);
    end
  end

endmodule
